FILE: sv/ahsm_pkg.sv
`timescale 1ns / 1ps
package ahsm_pkg;

  // Field widths fixed by the item format.
  localparam int IDX_W   = 10;
  localparam int POS_W   = 20;
  localparam int SPD_W   = 16;
  localparam int HDG_W   = 16;
  localparam int LIM_W   = 13;
  localparam int TDATA_W = 88;

  // CORDIC datapath width: 24 fraction bits plus integer headroom and growth.
  localparam int VEC_W   = 36;
  localparam int VEC_FRAC = 24;
  localparam int MAX_STAGES = 24;

  // Inverse CORDIC gain in Q0.16.
  localparam logic signed [16:0] KINV = 17'sd39797;

  // Motion values given to an entry by a load.
  localparam logic signed [SPD_W-1:0] SPD_INIT = 16'sd256;
  localparam logic [HDG_W-1:0]        HDG_INIT = '0;

  // Front-to-back queue.
  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = 3;

  // Item modes.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // An item after the front has settled its speed and heading.
  typedef struct packed {
    logic                    mode;
    logic [IDX_W-1:0]        idx;
    logic [POS_W-1:0]        lx;
    logic [POS_W-1:0]        ly;
    logic signed [SPD_W-1:0] spd;
    logic [HDG_W-1:0]        hdg;
  } item_t;

  localparam int ITEM_W = $bits(item_t);

  // Angle of CORDIC stage i, full turn 2^32.
  function automatic logic signed [VEC_W-1:0] atan_val(input int i);
    logic signed [VEC_W-1:0] r;
    case (i)
      0:  r = 36'sd536870912;
      1:  r = 36'sd316933406;
      2:  r = 36'sd167458907;
      3:  r = 36'sd85004756;
      4:  r = 36'sd42667331;
      5:  r = 36'sd21354465;
      6:  r = 36'sd10679838;
      7:  r = 36'sd5340245;
      8:  r = 36'sd2670163;
      9:  r = 36'sd1335087;
      10: r = 36'sd667544;
      11: r = 36'sd333772;
      12: r = 36'sd166886;
      13: r = 36'sd83443;
      14: r = 36'sd41722;
      15: r = 36'sd20861;
      16: r = 36'sd10430;
      17: r = 36'sd5215;
      18: r = 36'sd2608;
      19: r = 36'sd1304;
      20: r = 36'sd652;
      21: r = 36'sd326;
      22: r = 36'sd163;
      23: r = 36'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a signed position to 0 .. m.
  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [VEC_W-1:0] v,
                                                 input logic [POS_W-1:0] m);
    logic signed [VEC_W-1:0] ms;
    logic [POS_W-1:0] r;
    ms = $signed({{(VEC_W-POS_W){1'b0}}, m});
    if (v < 0) begin
      r = '0;
    end else if (v > ms) begin
      r = m;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/ahsm_queue.sv
`timescale 1ns / 1ps
module ahsm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         din,
  input  logic                     pop,
  output logic [WIDTH-1:0]         dout,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

FILE: sv/ahsm_front.sv
`timescale 1ns / 1ps
module ahsm_front
  import ahsm_pkg::*;
#(
  parameter int AGENT_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic [Q_CNT_W-1:0] q_count,
  output logic               q_push,
  output item_t              q_item
);

  localparam int AW = (AGENT_COUNT > 1) ? $clog2(AGENT_COUNT) : 1;

  logic                    accept, idx_ok;
  logic [IDX_W-1:0]        in_idx;
  logic [AW-1:0]           rd_addr;
  logic [31:0]             hs_mem_r [AGENT_COUNT];
  logic [31:0]             rd_data_r;

  logic                    clearing_r;
  logic [AW-1:0]           clr_cnt_r;

  logic                    f1_v_r, f1_mode_r;
  logic [IDX_W-1:0]        f1_idx_r;
  logic [POS_W-1:0]        f1_lx_r, f1_ly_r;
  logic signed [SPD_W-1:0] f1_ds_r;
  logic [HDG_W-1:0]        f1_dh_r;

  logic                    lw_v_r;
  logic [IDX_W-1:0]        lw_idx_r;
  logic [31:0]             lw_data_r;

  logic [31:0]             old_data, new_data, wr_data;
  logic signed [SPD_W:0]   spd_sum;
  logic signed [SPD_W-1:0] spd_new;
  logic [HDG_W-1:0]        hdg_new;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;

  assign in_idx    = in_tdata[9:0];
  assign idx_ok    = ({22'd0, in_idx} < 32'(AGENT_COUNT));
  assign rd_addr   = AW'(in_idx);
  assign in_tready = !clearing_r &&
                     ((4'(q_count) + 4'(f1_v_r)) < 4'(Q_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // Clearing pass over the motion store after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(AGENT_COUNT - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Registered read of heading and speed for the beat being taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= hs_mem_r[rd_addr];
    end
  end

  // Store write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hs_mem_r[wr_addr] <= wr_data;
    end
  end

  // Stage holding the accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      lw_v_r <= 1'b0;
    end else begin
      f1_v_r <= accept && idx_ok;
      lw_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_mode_r <= in_tuser;
      f1_idx_r  <= in_idx;
      f1_lx_r   <= in_tdata[29:10];
      f1_ly_r   <= in_tdata[49:30];
      f1_ds_r   <= $signed(in_tdata[65:50]);
      f1_dh_r   <= in_tdata[81:66];
    end
    lw_idx_r  <= f1_idx_r;
    lw_data_r <= new_data;
  end

  // Speed and heading update, forwarding the write made in the previous cycle.
  always_comb begin
    old_data = (lw_v_r && (lw_idx_r == f1_idx_r)) ? lw_data_r : rd_data_r;
    spd_sum  = 17'($signed(old_data[15:0])) + 17'(f1_ds_r);
    if (spd_sum > 17'sd32767) begin
      spd_new = 16'sh7FFF;
    end else if (spd_sum < -17'sd32768) begin
      spd_new = 16'sh8000;
    end else begin
      spd_new = spd_sum[SPD_W-1:0];
    end
    hdg_new = old_data[31:16] + f1_dh_r;
    if (f1_mode_r == MODE_LOAD) begin
      new_data = {HDG_INIT, SPD_INIT};
    end else begin
      new_data = {hdg_new, spd_new};
    end
  end

  // Write selection: the clearing pass or the current beat.
  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_r;
      wr_data = {HDG_INIT, SPD_INIT};
    end else begin
      wr_en   = f1_v_r;
      wr_addr = AW'(f1_idx_r);
      wr_data = new_data;
    end
  end

  assign q_push      = f1_v_r;
  assign q_item.mode = f1_mode_r;
  assign q_item.idx  = f1_idx_r;
  assign q_item.lx   = f1_lx_r;
  assign q_item.ly   = f1_ly_r;
  assign q_item.spd  = $signed(new_data[15:0]);
  assign q_item.hdg  = new_data[31:16];

endmodule

FILE: sv/ahsm_back.sv
`timescale 1ns / 1ps
module ahsm_back
  import ahsm_pkg::*;
#(
  parameter int AGENT_COUNT   = 1024,
  parameter int CORDIC_STAGES = 16,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [LIM_W-1:0]   cfg_data,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata
);

  localparam int AW     = (AGENT_COUNT > 1) ? $clog2(AGENT_COUNT) : 1;
  localparam int N      = CORDIC_STAGES;
  localparam int ODEPTH = 2 ** $clog2(CORDIC_STAGES + 6);
  localparam int OCW    = $clog2(ODEPTH) + 1;
  localparam int SH     = VEC_FRAC - POS_FRAC_BITS;
  localparam logic signed [VEC_W-1:0] RND = VEC_W'(64'd1 << (SH - 1));

  logic [LIM_W-1:0]        width_r, height_r;
  logic [POS_W-1:0]        max_x_r, max_y_r;

  item_t                   pay_r [N+1];
  logic                    v_r   [N+1];
  logic signed [VEC_W-1:0] x_r   [N+1];
  logic signed [VEC_W-1:0] y_r   [N+1];
  logic signed [VEC_W-1:0] z_r   [N+1];

  logic                    flip;
  logic signed [16:0]      kmul;
  logic signed [33:0]      prod;
  logic signed [HDG_W-1:0] ang;

  item_t                   r_pay_r;
  logic                    r_v_r;
  logic signed [VEC_W-1:0] dx_r, dy_r;

  logic [2*POS_W-1:0]      pos_mem_r [AGENT_COUNT];
  logic [2*POS_W-1:0]      pos_rd_r, old_pos;
  logic                    lw_v_r;
  logic [IDX_W-1:0]        lw_idx_r;
  logic [2*POS_W-1:0]      lw_pos_r;
  logic [POS_W-1:0]        nx, ny;

  logic [7:0]              infl_r;
  logic [OCW-1:0]          ocount;
  logic                    oempty, opop;
  logic [TDATA_W-1:0]      res;

  function automatic logic [POS_W-1:0] lim_max(input logic [LIM_W-1:0] lim);
    logic [31:0] m;
    if (lim == '0) begin
      m = '0;
    end else begin
      m = (32'(lim) - 32'd1) << POS_FRAC_BITS;
      if (m > 32'h000F_FFFF) begin
        m = 32'h000F_FFFF;
      end
    end
    return m[POS_W-1:0];
  endfunction

  // Configuration registers and the clamp limits derived from them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 13'd1024;
      height_r <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    max_x_r <= lim_max(width_r);
    max_y_r <= lim_max(height_r);
  end

  // Issue from the queue while the output buffer has room for all beats in flight.
  assign q_pop = !q_empty && ((9'(infl_r) + 9'(ocount)) < 9'(ODEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= '0;
    end else begin
      infl_r <= infl_r + 8'(q_pop) - 8'(r_v_r);
    end
  end

  // Entry stage: scale the speed by the inverse gain and fold the angle.
  assign flip = q_item.hdg[15] ^ q_item.hdg[14];
  assign kmul = flip ? -KINV : KINV;
  assign prod = q_item.spd * kmul;
  assign ang  = $signed(flip ? (q_item.hdg ^ 16'h8000) : q_item.hdg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    pay_r[0] <= q_item;
    x_r[0]   <= {{(VEC_W-34){prod[33]}}, prod};
    y_r[0]   <= '0;
    z_r[0]   <= {{(VEC_W-32){ang[15]}}, ang, 16'd0};
  end

  // CORDIC rotation stages, one micro-rotation each.
  for (genvar k = 1; k <= N; k++) begin : g_cordic
    logic signed [VEC_W-1:0] xs, ys;
    assign xs = x_r[k-1] >>> (k - 1);
    assign ys = y_r[k-1] >>> (k - 1);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      pay_r[k] <= pay_r[k-1];
      if (!z_r[k-1][VEC_W-1]) begin
        x_r[k] <= x_r[k-1] - ys;
        y_r[k] <= y_r[k-1] + xs;
        z_r[k] <= z_r[k-1] - atan_val(k - 1);
      end else begin
        x_r[k] <= x_r[k-1] + ys;
        y_r[k] <= y_r[k-1] - xs;
        z_r[k] <= z_r[k-1] + atan_val(k - 1);
      end
    end
  end

  // Round to position units and read the old position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r  <= 1'b0;
      lw_v_r <= 1'b0;
    end else begin
      r_v_r  <= v_r[N];
      lw_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    r_pay_r <= pay_r[N];
    dx_r    <= (x_r[N] + RND) >>> SH;
    dy_r    <= (y_r[N] + RND) >>> SH;
    if (v_r[N]) begin
      pos_rd_r <= pos_mem_r[AW'(pay_r[N].idx)];
    end
  end

  // Position update with forwarding of the write made in the previous cycle.
  always_comb begin
    old_pos = (lw_v_r && (lw_idx_r == r_pay_r.idx)) ? lw_pos_r : pos_rd_r;
    if (r_pay_r.mode == MODE_ADVANCE) begin
      nx = clamp_pos($signed({{(VEC_W-POS_W){1'b0}}, old_pos[POS_W-1:0]}) + dx_r,
                     max_x_r);
      ny = clamp_pos($signed({{(VEC_W-POS_W){1'b0}}, old_pos[2*POS_W-1:POS_W]}) + dy_r,
                     max_y_r);
    end else begin
      nx = clamp_pos($signed({{(VEC_W-POS_W){1'b0}}, r_pay_r.lx}), max_x_r);
      ny = clamp_pos($signed({{(VEC_W-POS_W){1'b0}}, r_pay_r.ly}), max_y_r);
    end
  end

  always_ff @(posedge clk) begin
    if (r_v_r) begin
      pos_mem_r[AW'(r_pay_r.idx)] <= {ny, nx};
    end
  end

  always_ff @(posedge clk) begin
    lw_idx_r <= r_pay_r.idx;
    lw_pos_r <= {ny, nx};
  end

  // Output buffer.
  assign res = {6'd0, r_pay_r.hdg, r_pay_r.spd, ny, nx, r_pay_r.idx};
  assign opop = out_tvalid && out_tready;

  ahsm_queue #(
    .WIDTH (TDATA_W),
    .DEPTH (ODEPTH)
  ) u_obuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_v_r),
    .din   (res),
    .pop   (opop),
    .dout  (out_tdata),
    .empty (oempty),
    .count (ocount)
  );

  assign out_tvalid = !oempty;

endmodule

FILE: sv/agent_heading_speed_move.sv
`timescale 1ns / 1ps
// A beat passes the front stage, the queue, then the entry, CORDIC and rounding stages.
// Throughput: one beat per cycle while the result side takes beats, set by the pipelined
// CORDIC and the single-port reads of the motion and position stores, with forwarding on
// repeats. Reset: synchronous, active low; afterwards the motion store is cleared entry by
// entry while in_tready stays low. Configuration is taken meanwhile.
module agent_heading_speed_move
  import ahsm_pkg::*;
#(
  parameter int AGENT_COUNT   = 1024,
  parameter int CORDIC_STAGES = 16,
  parameter int POS_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               in_tuser,   // mode
  // agent_index, load_x, load_y, delta_speed_in, delta_heading_in
  input  logic [TDATA_W-1:0] in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // out_index, new_x, new_y, new_speed, new_heading
  output logic [TDATA_W-1:0] out_tdata,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [LIM_W-1:0]   cfg_data
);

  logic               f_push, q_pop, q_empty;
  item_t              f_item, q_item;
  logic [ITEM_W-1:0]  q_dout;
  logic [Q_CNT_W-1:0] q_count;

  // Front: accept beats and settle speed and heading.
  ahsm_front #(
    .AGENT_COUNT (AGENT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_count   (q_count),
    .q_push    (f_push),
    .q_item    (f_item)
  );

  // Queue between front and back.
  ahsm_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (f_item),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  assign q_item = item_t'(q_dout);

  // Back: rotation, position update and result buffer.
  ahsm_back #(
    .AGENT_COUNT   (AGENT_COUNT),
    .CORDIC_STAGES (CORDIC_STAGES),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sv/ahsm_check.sv
`timescale 1ns / 1ps
module ahsm_check
  import ahsm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_tvalid,
  input logic               in_tready,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [TDATA_W-1:0] out_tdata
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its data.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result data changed while stalled");

  // The store clearing pass holds off input right after reset.
  a_clear_hold: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken during store clearing");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind agent_heading_speed_move ahsm_check u_ahsm_check (.*);

FILE: bench/agent_heading_speed_move_chk.sv
`timescale 1ns / 1ps
module agent_heading_speed_move_chk
  import ahsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic               in_tuser,
  input  logic [TDATA_W-1:0] in_tdata,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [TDATA_W-1:0] out_tdata,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [LIM_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam int AGENTS = 1024;
  localparam int STAGES = 16;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [SPD_W-1:0] spd;
    logic [HDG_W-1:0] hdg;
  } agent_state_t;

  // Angle of each rotation stage, full turn 2^32.
  localparam longint TURN_ANGLE [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  logic [POS_W-1:0] pos_x [AGENTS];
  logic [POS_W-1:0] pos_y [AGENTS];
  logic [SPD_W-1:0] speed [AGENTS];
  logic [HDG_W-1:0] heading [AGENTS];
  logic [LIM_W-1:0] field_w;
  logic [LIM_W-1:0] field_h;
  agent_state_t     moves_due [$];

  // Largest position allowed by a field limit.
  function automatic longint edge_of(input logic [LIM_W-1:0] lim);
    longint m;
    if (lim == 0) begin
      return 0;
    end
    m = longint'(lim - 1) << 8;
    if (m > 64'hFFFFF) begin
      m = 64'hFFFFF;
    end
    return m;
  endfunction

  function automatic logic [POS_W-1:0] keep_in(input longint v, input logic [LIM_W-1:0] lim);
    longint m;
    m = edge_of(lim);
    if (v < 0) begin
      v = 0;
    end
    if (v > m) begin
      v = m;
    end
    return v[POS_W-1:0];
  endfunction

  // Turn the vector (spd, 0) by the heading and return the step in position units.
  task automatic step_vector(input int spd, input logic [HDG_W-1:0] hdg,
                             output longint dx, output longint dy);
    longint x, y, z, xs, ys;
    int a;
    x = longint'(spd) * 39797;
    y = 0;
    a = int'(hdg);
    if (a >= 'h4000 && a < 'hC000) begin
      x = -x;
      a = a - 'h8000;
    end else if (a >= 'hC000) begin
      a = a - 'h10000;
    end
    z = longint'(a) * 65536;
    for (int i = 0; i < STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - TURN_ANGLE[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + TURN_ANGLE[i];
      end
    end
    dx = (x + (64'sd1 <<< 15)) >>> 16;
    dy = (y + (64'sd1 <<< 15)) >>> 16;
  endtask

  // Apply one beat to the agent table and return the entry's new contents.
  task automatic move_agent(input logic mode, input logic [TDATA_W-1:0] d,
                            output agent_state_t r);
    logic [IDX_W-1:0] idx;
    int sp;
    longint dx, dy;
    idx = d[9:0];
    if (mode == MODE_LOAD) begin
      pos_x[idx] = keep_in(longint'(d[29:10]), field_w);
      pos_y[idx] = keep_in(longint'(d[49:30]), field_h);
      heading[idx] = HDG_INIT;
      speed[idx] = SPD_INIT;
    end else begin
      sp = int'($signed(speed[idx])) + int'($signed(d[65:50]));
      if (sp > 32767) begin
        sp = 32767;
      end
      if (sp < -32768) begin
        sp = -32768;
      end
      speed[idx] = sp[15:0];
      heading[idx] = heading[idx] + d[81:66];
      step_vector(sp, heading[idx], dx, dy);
      pos_x[idx] = keep_in(longint'(pos_x[idx]) + dx, field_w);
      pos_y[idx] = keep_in(longint'(pos_y[idx]) + dy, field_h);
    end
    r.idx = idx;
    r.x = pos_x[idx];
    r.y = pos_y[idx];
    r.spd = speed[idx];
    r.hdg = heading[idx];
  endtask

  // Track configuration, predict on each input beat and compare each result beat.
  always @(posedge clk) begin
    agent_state_t e;
    if (!rst_n) begin
      for (int i = 0; i < AGENTS; i++) begin
        pos_x[i] = '0;
        pos_y[i] = '0;
        heading[i] = '0;
        speed[i] = 16'd256;
      end
      field_w = 13'd1024;
      field_h = 13'd1024;
      moves_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) begin
          field_w = cfg_data;
        end else if (cfg_index == REG_HEIGHT) begin
          field_h = cfg_data;
        end
      end
      if (in_tvalid && in_tready) begin
        move_agent(in_tuser, in_tdata, e);
        moves_due.push_back(e);
      end
      if (out_tvalid && out_tready) begin
        if (moves_due.size() == 0) begin
          $error("result beat with nothing expected: %h", out_tdata);
          fail_count++;
        end else begin
          e = moves_due.pop_front();
          if (out_tdata[9:0] != e.idx) begin
            $error("out_index expected %0d got %0d", e.idx, out_tdata[9:0]);
            fail_count++;
          end
          if (out_tdata[29:10] != e.x) begin
            $error("new_x expected %h got %h", e.x, out_tdata[29:10]);
            fail_count++;
          end
          if (out_tdata[49:30] != e.y) begin
            $error("new_y expected %h got %h", e.y, out_tdata[49:30]);
            fail_count++;
          end
          if (out_tdata[65:50] != e.spd) begin
            $error("new_speed expected %h got %h", e.spd, out_tdata[65:50]);
            fail_count++;
          end
          if (out_tdata[81:66] != e.hdg) begin
            $error("new_heading expected %h got %h", e.hdg, out_tdata[81:66]);
            fail_count++;
          end
        end
      end
    end
    pending = moves_due.size();
  end

endmodule

FILE: bench/agent_heading_speed_move_tb.sv
`timescale 1ns / 1ps
module agent_heading_speed_move_tb;
  import ahsm_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic               in_tuser = 1'b0;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = '0;
  logic [LIM_W-1:0]   cfg_data = '0;
  int                 fail_count;
  int                 pending;
  bit                 calm = 1'b0;
  bit                 placed [1024];
  int                 idle_cycles = 0;
  int                 beats_sent = 0;
  int                 sink_hold = 0;

  always #4 clk = ~clk;

  agent_heading_speed_move dut (.*);

  agent_heading_speed_move_chk chk (.*);

  // Result side: random stall bursts unless the run is in its calm tail.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_hold <= $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[agent_heading_speed_move] ERROR");
      $finish;
    end
  end

  // Present one beat and hold it until taken, then maybe leave a gap.
  task automatic send(input logic mode, input logic [9:0] idx, input logic [19:0] lx,
                      input logic [19:0] ly, input logic [15:0] ds, input logic [15:0] dh);
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {6'b0, dh, ds, ly, lx, idx};
    do begin
      @(negedge clk);
    end while (!in_tready);
    @(posedge clk);
    beats_sent++;
    if (mode == MODE_LOAD) begin
      placed[idx] = 1'b1;
    end
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain;
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic set_field(input logic [LIM_W-1:0] w, input logic [LIM_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly advances on a small set of agents so that repeats follow closely.
  task automatic random_beat;
    logic [9:0] idx;
    logic [19:0] lx, ly;
    logic [15:0] ds, dh;
    idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
    lx = 20'($urandom);
    ly = 20'($urandom);
    ds = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023) - 512);
    dh = 16'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      ds = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    end
    if (!placed[idx] || $urandom_range(0, 7) == 0) begin
      send(MODE_LOAD, idx, lx, ly, ds, dh);
    end else begin
      send(MODE_ADVANCE, idx, lx, ly, ds, dh);
    end
  endtask

  initial begin
    logic [LIM_W-1:0] widths [5];
    logic [LIM_W-1:0] heights [5];
    widths = '{13'd0, 13'd1, 13'd4096, 13'h1FFF, 13'd1024};
    heights = '{13'd4096, 13'h1FFF, 13'd1, 13'd0, 13'd1024};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_field(13'd1024, 13'd1024);

    // Directed: corners, saturation both ways and the quadrant boundaries.
    send(MODE_LOAD, 10'd0, 20'd0, 20'd0, 16'h0000, 16'h0000);
    send(MODE_LOAD, 10'd1023, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF);
    send(MODE_ADVANCE, 10'd0, 20'hFFFFF, 20'hFFFFF, 16'h7FFF, 16'h4000);
    send(MODE_ADVANCE, 10'd0, 20'd0, 20'd0, 16'h7FFF, 16'h0000);
    send(MODE_ADVANCE, 10'd0, 20'd0, 20'd0, 16'h8000, 16'h8000);
    send(MODE_ADVANCE, 10'd1023, 20'd0, 20'd0, 16'h8000, 16'hC000);
    send(MODE_ADVANCE, 10'd1023, 20'd0, 20'd0, 16'h8000, 16'hFFFF);
    send(MODE_ADVANCE, 10'd1023, 20'd0, 20'd0, 16'h7FFF, 16'h3FFF);
    send(MODE_LOAD, 10'd5, 20'h40000, 20'h40000, 16'h0000, 16'h0000);
    send(MODE_ADVANCE, 10'd5, 20'd0, 20'd0, 16'h0100, 16'h3FFF);
    send(MODE_ADVANCE, 10'd5, 20'd0, 20'd0, 16'h0000, 16'h8001);
    send(MODE_ADVANCE, 10'd5, 20'd0, 20'd0, 16'hFF00, 16'h4000);
    send(MODE_ADVANCE, 10'd5, 20'd0, 20'd0, 16'h0000, 16'h4000);
    send(MODE_LOAD, 10'd5, 20'h80000, 20'h00001, 16'h0000, 16'h0000);
    send(MODE_ADVANCE, 10'd5, 20'd0, 20'd0, 16'h0000, 16'hBFFF);

    // Random phases, each under its own field size; the last one runs calm.
    for (int p = 0; p < 5; p++) begin
      drain();
      set_field(widths[p], heights[p]);
      calm = (p == 4);
      for (int n = 0; n < 100; n++) begin
        random_beat();
        if (n == 50 && p == 1) begin
          drain();
        end
      end
    end
    drain();

    $display("Sent %0d beats of loads and advances over five field sizes,", beats_sent);
    $display("including zero and oversized limits and speed saturation.");
    if (fail_count == 0) begin
      $display("[agent_heading_speed_move] OK");
    end else begin
      $display("[agent_heading_speed_move] ERROR");
    end
    $finish;
  end

endmodule

FILE: agent_heading_speed_move.f
sv/ahsm_pkg.sv
sv/ahsm_queue.sv
sv/ahsm_front.sv
sv/ahsm_back.sv
sv/agent_heading_speed_move.sv
sv/ahsm_check.sv
bench/agent_heading_speed_move_chk.sv
bench/agent_heading_speed_move_tb.sv
